// ===== rtl/pabn_pkg.sv =====
// Shared types, constants and arithmetic helpers for the palette blend block.
package pabn_pkg;

	localparam int PALETTE_SIZE = 256;
	localparam int PAL_AW       = $clog2(PALETTE_SIZE);
	localparam int IDX_W        = 8;
	localparam int CH_W         = 8;
	localparam int RGB_W        = 3 * CH_W;
	localparam int CMD_W        = 2;
	localparam int LEVEL_W      = 3;
	localparam int LEVEL_SHIFT  = 5;
	localparam int MID_LEVELS   = 6;
	localparam int BG_ROWS      = 256;
	localparam int CACHE_DEPTH  = MID_LEVELS * BG_ROWS;
	localparam int CACHE_AW     = $clog2(CACHE_DEPTH);
	localparam int SUM_W        = 11;
	localparam int SQ_W         = 2 * CH_W;
	localparam int DIST_W       = 23;
	localparam int DIV7_SHIFT   = 14;
	localparam int PROD_W       = 23;

	localparam logic [LEVEL_W-1:0] LEVEL_ZERO = 3'd0;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 3'd7;
	localparam logic [6:0]         W_RED      = 7'd30;
	localparam logic [6:0]         W_GREEN    = 7'd59;
	localparam logic [6:0]         W_BLUE     = 7'd11;
	// ceil(2^14 / 7): exact floor(x / 7) for every x below 2^11
	localparam logic [11:0]        DIV7_MUL   = 12'd2341;

	localparam logic [PAL_AW-1:0]  PAL_LAST   = PAL_AW'(PALETTE_SIZE - 1);
	localparam logic [IDX_W:0]     PAL_LIM    = (IDX_W + 1)'(PALETTE_SIZE);

	typedef enum logic [CMD_W-1:0] {
		CMD_BLEND  = 2'd0,
		CMD_PAL_WR = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	// source of the delivered result
	typedef enum logic [2:0] {
		RES_ZERO = 3'd0,
		RES_BG   = 3'd1,
		RES_FG   = 3'd2,
		RES_HIT  = 3'd3,
		RES_SCAN = 3'd4
	} res_sel_t;

	typedef struct packed {
		logic     capture;
		logic     pal_wr;
		logic     cache_clr;
		logic     lookup;
		logic     rd_bg;
		logic     mix_sum;
		logic     mix_div;
		logic     scan_start;
		logic     writeback;
		logic     out_load;
		res_sel_t res_sel;
	} ctl_cmd_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [LEVEL_W-1:0] level;
		logic               hit;
		logic               scan_busy;
	} dp_status_t;

	function automatic logic [SUM_W-1:0] blend_sum(input logic [CH_W-1:0] f,
			input logic [CH_W-1:0] b, input logic [LEVEL_W-1:0] a);
		logic [LEVEL_W-1:0] na;
		na = LEVEL_MAX - a;
		return SUM_W'(f) * SUM_W'(a) + SUM_W'(b) * SUM_W'(na);
	endfunction

	function automatic logic [CH_W-1:0] div7(input logic [SUM_W-1:0] x);
		logic [PROD_W-1:0] p;
		p = PROD_W'(x) * PROD_W'(DIV7_MUL);
		return p[DIV7_SHIFT +: CH_W];
	endfunction

	function automatic logic [SQ_W-1:0] sq_diff(input logic [CH_W-1:0] a,
			input logic [CH_W-1:0] b);
		logic [CH_W-1:0] d;
		d = (a > b) ? a - b : b - a;
		return SQ_W'(d) * SQ_W'(d);
	endfunction

endpackage

// ===== rtl/palette_alpha_blend_nearest.sv =====
// Level 0/7, palette write, clear and unused commands go from decode to the result load; a
//   cache hit adds the lookup; a cache miss adds the mix, then a full palette scan paced by the
//   one-entry-per-cycle palette read port feeding the 3-stage distance pipeline, then the write-back.
// One request in flight; next request taken once the result sits in the output register.
// Reset: fg_color 0, palette valid bits and blend cache row valid bits cleared at once,
//   so the palette reads as black and the cache as empty; no clearing pass.
module palette_alpha_blend_nearest (
	input  logic       clk,
	input  logic       arst_n,
	// configuration: foreground palette index
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	// request channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] cmd,
	input  logic [7:0] coverage,
	input  logic [7:0] bg_index,
	input  logic [7:0] pal_index,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	// result channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] pixel_index,
	output logic       write_pixel,
	output logic       cache_hit
);
	import pabn_pkg::*;

	logic [IDX_W-1:0] fg_color_q;
	ctl_cmd_t         ctl;
	dp_status_t       st;

	// fg_color must only change while idle; this is the user's duty, unchecked here, and the datapath reads it directly
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_color_q <= '0;
		end else if (cfg_we) begin
			fg_color_q <= cfg_wdata;
		end
	end

	// sequencer: decode, cache lookup, mix, scan, cache write-back, result load
	pabn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.st        (st),
		.ctl       (ctl)
	);

	// memories, blend arithmetic, nearest-color search and result register
	pabn_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.coverage    (coverage),
		.bg_index    (bg_index),
		.pal_index   (pal_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.fg_color    (fg_color_q),
		.ctl         (ctl),
		.st          (st),
		.pixel_index (pixel_index),
		.write_pixel (write_pixel),
		.cache_hit   (cache_hit)
	);

endmodule

// ===== rtl/pabn_dp.sv =====
// Datapath: palette and blend cache memories, channel mix, nearest-color scan pipeline.
module pabn_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [1:0]            cmd,
	input  logic [7:0]            coverage,
	input  logic [7:0]            bg_index,
	input  logic [7:0]            pal_index,
	input  logic [7:0]            red,
	input  logic [7:0]            green,
	input  logic [7:0]            blue,
	input  logic [7:0]            fg_color,
	input  pabn_pkg::ctl_cmd_t    ctl,
	output pabn_pkg::dp_status_t  st,
	output logic [7:0]            pixel_index,
	output logic                  write_pixel,
	output logic                  cache_hit
);
	import pabn_pkg::*;

	// captured request
	cmd_t               cmd_q;
	logic [LEVEL_W-1:0] lvl_q;
	logic [IDX_W-1:0]   bg_q;
	logic [IDX_W-1:0]   pidx_q;
	logic [RGB_W-1:0]   wr_rgb_q;

	// palette
	logic [RGB_W-1:0]        pal_mem [PALETTE_SIZE];
	logic [PALETTE_SIZE-1:0] pal_vld_q;
	logic [RGB_W-1:0]        pal_rd_q;
	logic                    pal_rd_vld_q;
	logic [IDX_W-1:0]        rd_addr;
	logic                    rd_en;
	logic [RGB_W-1:0]        pal_rd;

	// blend cache
	logic [IDX_W-1:0]      cache_mem [CACHE_DEPTH];
	logic [MID_LEVELS-1:0] vrow_mem [BG_ROWS];
	logic [BG_ROWS-1:0]    row_vld_q;
	logic [IDX_W-1:0]      cache_rd_q;
	logic [MID_LEVELS-1:0] vrow_rd_q;
	logic                  row_vld_rd_q;
	logic [LEVEL_W-1:0]    lvl_m1;
	logic [CACHE_AW-1:0]   caddr;
	logic [MID_LEVELS-1:0] lvl_bit;
	logic [MID_LEVELS-1:0] vrow_eff;

	// mix
	logic [RGB_W-1:0] fg_rgb_q;
	logic [SUM_W-1:0] sum_r_q, sum_g_q, sum_b_q;
	logic [CH_W-1:0]  tgt_r_q, tgt_g_q, tgt_b_q;

	// scan pipeline
	logic              scan_active_q;
	logic [PAL_AW-1:0] scan_idx_q;
	logic              v_s1, v_s2, v_s3;
	logic [PAL_AW-1:0] idx_s1, idx_s2, idx_s3;
	logic [SQ_W-1:0]   sq_r_s2, sq_g_s2, sq_b_s2;
	logic [DIST_W-1:0] dist_s3;
	logic              have_q;
	logic [DIST_W-1:0] best_dist_q;
	logic [PAL_AW-1:0] best_idx_q;

	assign lvl_m1   = lvl_q - LEVEL_W'(1);
	assign caddr    = {lvl_m1, bg_q};
	assign lvl_bit  = MID_LEVELS'(1) << lvl_m1;
	assign vrow_eff = row_vld_rd_q ? vrow_rd_q : '0;
	assign pal_rd   = pal_rd_vld_q ? pal_rd_q : '0;

	assign st.cmd       = cmd_q;
	assign st.level     = lvl_q;
	assign st.hit       = |(vrow_eff & lvl_bit);
	assign st.scan_busy = scan_active_q | v_s1 | v_s2 | v_s3;

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q    <= cmd_t'(cmd);
			lvl_q    <= coverage[LEVEL_SHIFT +: LEVEL_W];
			bg_q     <= bg_index;
			pidx_q   <= pal_index;
			wr_rgb_q <= {red, green, blue};
		end
	end

	// palette read port: scan has priority, then background, then foreground
	always_comb begin
		rd_en = scan_active_q | ctl.rd_bg | ctl.lookup;
		if (scan_active_q) begin
			rd_addr = IDX_W'(scan_idx_q);
		end else if (ctl.rd_bg) begin
			rd_addr = bg_q;
		end else begin
			rd_addr = fg_color;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pal_wr && ({1'b0, pidx_q} < PAL_LIM)) begin
			pal_mem[pidx_q[PAL_AW-1:0]] <= wr_rgb_q;
		end
		if (rd_en) begin
			pal_rd_q <= pal_mem[rd_addr[PAL_AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_vld_q    <= '0;
			pal_rd_vld_q <= 1'b0;
		end else begin
			if (ctl.pal_wr && ({1'b0, pidx_q} < PAL_LIM)) begin
				pal_vld_q[pidx_q[PAL_AW-1:0]] <= 1'b1;
			end
			if (rd_en) begin
				pal_rd_vld_q <= ({1'b0, rd_addr} < PAL_LIM) &&
					pal_vld_q[rd_addr[PAL_AW-1:0]];
			end
		end
	end

	// blend cache memories
	always_ff @(posedge clk) begin
		if (ctl.lookup) begin
			cache_rd_q <= cache_mem[caddr];
			vrow_rd_q  <= vrow_mem[bg_q];
		end
		if (ctl.writeback) begin
			cache_mem[caddr] <= IDX_W'(best_idx_q);
			vrow_mem[bg_q]   <= vrow_eff | lvl_bit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q    <= '0;
			row_vld_rd_q <= 1'b0;
		end else begin
			if (ctl.lookup) begin
				row_vld_rd_q <= row_vld_q[bg_q];
			end
			if (ctl.cache_clr) begin
				row_vld_q <= '0;
			end else if (ctl.writeback) begin
				row_vld_q[bg_q] <= 1'b1;
			end
		end
	end

	// channel mix: weighted sum, then exact divide by seven
	always_ff @(posedge clk) begin
		if (ctl.rd_bg) begin
			fg_rgb_q <= pal_rd;
		end
		if (ctl.mix_sum) begin
			sum_r_q <= blend_sum(fg_rgb_q[2*CH_W +: CH_W], pal_rd[2*CH_W +: CH_W], lvl_q);
			sum_g_q <= blend_sum(fg_rgb_q[CH_W +: CH_W], pal_rd[CH_W +: CH_W], lvl_q);
			sum_b_q <= blend_sum(fg_rgb_q[0 +: CH_W], pal_rd[0 +: CH_W], lvl_q);
		end
		if (ctl.mix_div) begin
			tgt_r_q <= div7(sum_r_q);
			tgt_g_q <= div7(sum_g_q);
			tgt_b_q <= div7(sum_b_q);
		end
	end

	// scan control and pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_active_q <= 1'b0;
			scan_idx_q    <= '0;
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			v_s3          <= 1'b0;
			have_q        <= 1'b0;
		end else begin
			v_s1 <= scan_active_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (ctl.scan_start) begin
				scan_active_q <= 1'b1;
				scan_idx_q    <= '0;
				have_q        <= 1'b0;
			end else begin
				if (scan_active_q) begin
					scan_idx_q <= scan_idx_q + PAL_AW'(1);
					if (scan_idx_q == PAL_LAST) begin
						scan_active_q <= 1'b0;
					end
				end
				if (v_s3) begin
					have_q <= 1'b1;
				end
			end
		end
	end

	// s1: palette data, s2: squared differences, s3: weighted distance
	always_ff @(posedge clk) begin
		idx_s1  <= scan_idx_q;
		idx_s2  <= idx_s1;
		idx_s3  <= idx_s2;
		sq_r_s2 <= sq_diff(tgt_r_q, pal_rd[2*CH_W +: CH_W]);
		sq_g_s2 <= sq_diff(tgt_g_q, pal_rd[CH_W +: CH_W]);
		sq_b_s2 <= sq_diff(tgt_b_q, pal_rd[0 +: CH_W]);
		dist_s3 <= DIST_W'(sq_r_s2) * DIST_W'(W_RED) +
			DIST_W'(sq_g_s2) * DIST_W'(W_GREEN) +
			DIST_W'(sq_b_s2) * DIST_W'(W_BLUE);
		// strict compare keeps the lowest index on ties
		if (v_s3 && (!have_q || dist_s3 < best_dist_q)) begin
			best_dist_q <= dist_s3;
			best_idx_q  <= idx_s3;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			unique case (ctl.res_sel)
				RES_BG: begin
					pixel_index <= bg_q;
					write_pixel <= 1'b0;
					cache_hit   <= 1'b0;
				end
				RES_FG: begin
					pixel_index <= fg_color;
					write_pixel <= 1'b1;
					cache_hit   <= 1'b0;
				end
				RES_HIT: begin
					pixel_index <= cache_rd_q;
					write_pixel <= 1'b1;
					cache_hit   <= 1'b1;
				end
				RES_SCAN: begin
					pixel_index <= IDX_W'(best_idx_q);
					write_pixel <= 1'b1;
					cache_hit   <= 1'b0;
				end
				default: begin
					pixel_index <= '0;
					write_pixel <= 1'b0;
					cache_hit   <= 1'b0;
				end
			endcase
		end
	end

endmodule

// ===== rtl/pabn_ctrl.sv =====
// Controller: request sequencing state machine and output valid.
module pabn_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  pabn_pkg::dp_status_t st,
	output pabn_pkg::ctl_cmd_t   ctl
);
	import pabn_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_LOOKUP,
		S_MIXSUM,
		S_MIXDIV,
		S_SCAN,
		S_WRBACK,
		S_FINISH
	} state_t;

	state_t   state_q;
	state_t   state_d;
	res_sel_t res_sel_q;
	res_sel_t res_sel_d;
	logic     out_valid_q;
	logic     out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		ctl         = '0;
		ctl.res_sel = res_sel_q;
		state_d     = state_q;
		res_sel_d   = res_sel_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				res_sel_d = RES_ZERO;
				state_d   = S_FINISH;
				unique case (st.cmd)
					CMD_BLEND: begin
						if (st.level == LEVEL_ZERO) begin
							res_sel_d = RES_BG;
						end else if (st.level == LEVEL_MAX) begin
							res_sel_d = RES_FG;
						end else begin
							ctl.lookup = 1'b1;
							state_d    = S_LOOKUP;
						end
					end
					CMD_PAL_WR: ctl.pal_wr = 1'b1;
					CMD_CLEAR:  ctl.cache_clr = 1'b1;
					CMD_NOP:    ;
				endcase
			end
			S_LOOKUP: begin
				if (st.hit) begin
					res_sel_d = RES_HIT;
					state_d   = S_FINISH;
				end else begin
					ctl.rd_bg = 1'b1;
					state_d   = S_MIXSUM;
				end
			end
			S_MIXSUM: begin
				ctl.mix_sum = 1'b1;
				state_d     = S_MIXDIV;
			end
			S_MIXDIV: begin
				ctl.mix_div    = 1'b1;
				ctl.scan_start = 1'b1;
				state_d        = S_SCAN;
			end
			S_SCAN: begin
				if (!st.scan_busy) begin
					state_d = S_WRBACK;
				end
			end
			S_WRBACK: begin
				ctl.writeback = 1'b1;
				res_sel_d     = RES_SCAN;
				state_d       = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) begin
					ctl.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_sel_q   <= RES_ZERO;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			res_sel_q <= res_sel_d;
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the palette blend / nearest-color block.
`timescale 1ns / 1ps

module tb_top;
	import pabn_pkg::*;

	// rough request budget for the random traffic phase
	localparam int RAND_ITEMS = 1950;
	// cycles with no handshake on either channel before the run is called hung;
	// a full palette scan, plus the random output stalls and request gaps, stays well inside it
	localparam int IDLE_LIMIT = 3000;
	// cycles to wait after the last result before closing the run
	localparam int TAIL_CYCLES = 300;

	typedef struct packed {
		logic [7:0] pix;
		logic       wr;
		logic       hit;
	} px_result_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;
	logic       in_valid;
	logic       in_stall;
	logic [1:0] cmd;
	logic [7:0] coverage;
	logic [7:0] bg_index;
	logic [7:0] pal_index;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] pixel_index;
	logic       write_pixel;
	logic       cache_hit;

	palette_alpha_blend_nearest u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.coverage    (coverage),
		.bg_index    (bg_index),
		.pal_index   (pal_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_index (pixel_index),
		.write_pixel (write_pixel),
		.cache_hit   (cache_hit)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------
	// Shadow state of the block: palette, blend cache, foreground index.
	// Updated in request order at the edge the request is accepted.
	// ------------------------------------------------------------------
	logic [23:0] pal_shadow [256];
	logic [7:0]  cache_px   [MID_LEVELS * BG_ROWS];
	logic [5:0]  cache_ok   [BG_ROWS];
	logic [7:0]  fg_sel;

	px_result_t  pending_px [$];

	// run bookkeeping
	bit no_idle;
	int n_sent, n_pal_wr, n_clear, n_cfg;
	int n_hits, n_scans, n_edge;
	int mism_cnt;
	int rand_cnt;
	int stall_left;
	int idle_cyc;

	// one channel of the blend, floor((f*a + b*(7-a)) / 7)
	function automatic int mix_chan(input int f, input int k, input int a);
		return (f * a + k * (int'(LEVEL_MAX) - a)) / int'(LEVEL_MAX);
	endfunction

	// weighted squared distance search, lowest index wins on ties
	function automatic logic [7:0] nearest_entry(input int r, input int g, input int b);
		int dr, dg, db, d, best_d, best;
		best = 0;
		best_d = 0;
		for (int i = 0; i < PALETTE_SIZE; i++) begin
			dr = r - int'(pal_shadow[i][23:16]);
			dg = g - int'(pal_shadow[i][15:8]);
			db = b - int'(pal_shadow[i][7:0]);
			d = dr * dr * int'(W_RED) + dg * dg * int'(W_GREEN) + db * db * int'(W_BLUE);
			if (i == 0 || d < best_d) begin
				best_d = d;
				best = i;
			end
		end
		return 8'(best);
	endfunction

	// expected result of one request; advances the shadow state
	function automatic px_result_t predict_pixel(input cmd_t c, input logic [7:0] cov,
			input logic [7:0] bg, input logic [7:0] pidx, input logic [7:0] r,
			input logic [7:0] g, input logic [7:0] b);
		px_result_t res;
		int lvl, slot;
		logic [23:0] f_rgb, k_rgb;
		res = '0;
		case (c)
			CMD_BLEND: begin
				lvl = int'(cov >> LEVEL_SHIFT);
				if (lvl == int'(LEVEL_ZERO)) begin
					res.pix = bg;
					n_edge++;
				end else if (lvl == int'(LEVEL_MAX)) begin
					res.pix = fg_sel;
					res.wr = 1'b1;
					n_edge++;
				end else begin
					res.wr = 1'b1;
					slot = (lvl - 1) * BG_ROWS + int'(bg);
					if (cache_ok[bg][lvl-1]) begin
						res.pix = cache_px[slot];
						res.hit = 1'b1;
						n_hits++;
					end else begin
						f_rgb = pal_shadow[fg_sel];
						k_rgb = pal_shadow[bg];
						res.pix = nearest_entry(
							mix_chan(f_rgb[23:16], k_rgb[23:16], lvl),
							mix_chan(f_rgb[15:8], k_rgb[15:8], lvl),
							mix_chan(f_rgb[7:0], k_rgb[7:0], lvl));
						cache_px[slot] = res.pix;
						cache_ok[bg][lvl-1] = 1'b1;
						n_scans++;
					end
				end
			end
			CMD_PAL_WR: begin
				if (int'(pidx) < PALETTE_SIZE)
					pal_shadow[pidx] = {r, g, b};
				n_pal_wr++;
			end
			CMD_CLEAR: begin
				foreach (cache_ok[i])
					cache_ok[i] = '0;
				n_clear++;
			end
			default: ;
		endcase
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Request side. Called at a rising edge; returns at the edge where the
	// request was taken, with in_valid still high so a back-to-back request
	// does not toggle it within one step.
	// ------------------------------------------------------------------
	task automatic send_req(input cmd_t c, input logic [7:0] cov, input logic [7:0] bg,
			input logic [7:0] pidx, input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		int gap;
		gap = no_idle ? 0 : $urandom_range(3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		cmd       <= c;
		coverage  <= cov;
		bg_index  <= bg;
		pal_index <= pidx;
		red       <= r;
		green     <= g;
		blue      <= b;
		do @(posedge clk); while (in_stall !== 1'b0);
		pending_px.push_back(predict_pixel(c, cov, bg, pidx, r, g, b));
		n_sent++;
	endtask

	// stop sending and let every pending result come back
	task automatic drain_requests();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_px.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// fg_color is only written with the block idle
	task automatic write_fg(input logic [7:0] v);
		drain_requests();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		fg_sel = v;
		n_cfg++;
	endtask

	// ------------------------------------------------------------------
	// Result side: per result, a randomly drawn stall (none when no_idle is
	// set) counted while out_valid is high, then compare against the oldest
	// pending expectation.
	always @(posedge clk) begin
		px_result_t exp_r;
		if (out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_px.size() == 0) begin
				mism_cnt++;
				if (mism_cnt <= 10)
					$display("[%0t] result with no request pending: pix=%0d wr=%0b hit=%0b",
						$realtime, pixel_index, write_pixel, cache_hit);
			end else begin
				exp_r = pending_px.pop_front();
				if (pixel_index !== exp_r.pix || write_pixel !== exp_r.wr ||
						cache_hit !== exp_r.hit) begin
					mism_cnt++;
					if (mism_cnt <= 10)
						$display("[%0t] mismatch: exp pix=%0d wr=%0b hit=%0b, got pix=%0d wr=%0b hit=%0b",
							$realtime, exp_r.pix, exp_r.wr, exp_r.hit,
							pixel_index, write_pixel, cache_hit);
				end
			end
			stall_left = no_idle ? 0 : $urandom_range(3);
		end else if (out_valid === 1'b1 && stall_left > 0) begin
			stall_left--;
		end
		out_stall <= (stall_left > 0);
	end

	// hang detector: counts cycles with no handshake on either channel
	always @(posedge clk) begin
		if ((in_valid === 1'b1 && in_stall === 1'b0) ||
				(out_valid === 1'b1 && out_stall === 1'b0))
			idle_cyc = 0;
		else
			idle_cyc++;
		if (idle_cyc >= IDLE_LIMIT) begin
			$display("[%0t] no handshake for %0d cycles, %0d results pending",
				$realtime, idle_cyc, pending_px.size());
			$display("palette_alpha_blend_nearest verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// after reset: black palette, fg 0, empty cache
	task automatic test_reset_state();
		send_req(CMD_BLEND, 8'hFF, 8'h5A, 8'h00, 8'h00, 8'h00, 8'h00); // full coverage -> fg
		send_req(CMD_BLEND, 8'h1F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF); // zero level -> bg
		send_req(CMD_BLEND, 8'h20, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00); // miss, all ties -> 0
		send_req(CMD_BLEND, 8'h3F, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00); // same slot -> hit
		send_req(CMD_NOP,   8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF); // unused command
	endtask

	// palette extremes, duplicate colors for tie-break, fg at top index
	task automatic test_palette_ties();
		write_fg(8'hFF);
		send_req(CMD_PAL_WR, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_req(CMD_PAL_WR, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00);
		send_req(CMD_PAL_WR, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00); // dup of entry 0
		send_req(CMD_PAL_WR, 8'h00, 8'h00, 8'h80, 8'h80, 8'h80, 8'h80);
		send_req(CMD_PAL_WR, 8'h00, 8'h00, 8'hAA, 8'h55, 8'hAA, 8'h55);
		send_req(CMD_CLEAR,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_req(CMD_BLEND,  8'hC0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00); // level 6
		send_req(CMD_BLEND,  8'h60, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00); // level 3
		send_req(CMD_BLEND,  8'hE0, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00); // level 7
		send_req(CMD_BLEND,  8'h5F, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00); // level 2
	endtask

	// cache survives palette writes and fg changes until an explicit clear
	task automatic test_stale_cache();
		send_req(CMD_PAL_WR, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00);
		send_req(CMD_BLEND,  8'hC0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00); // stale hit
		write_fg(8'h00);
		send_req(CMD_BLEND,  8'hDF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00); // still stale
		send_req(CMD_CLEAR,  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		send_req(CMD_BLEND,  8'hC0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00); // fresh search
	endtask

	// rounds of mostly blends over a small background set, mixed with palette
	// writes, clears and unused commands; fg_color changes between rounds
	task automatic test_random_traffic();
		logic [7:0] bg_pool [6];
		logic [7:0] bg, pidx;
		int n_round, pick;
		// fill part of the palette so the search has real colors to pick from
		repeat (32) begin
			send_req(CMD_PAL_WR, 8'($urandom), 8'($urandom), 8'($urandom),
				8'($urandom), 8'($urandom), 8'($urandom));
			rand_cnt++;
		end
		while (rand_cnt < RAND_ITEMS) begin
			// each round starts idle: drain, then a new foreground
			case ($urandom_range(3))
				0:       write_fg(8'h00);
				1:       write_fg(8'hFF);
				default: write_fg(8'($urandom));
			endcase
			no_idle = ($urandom_range(4) == 0);
			foreach (bg_pool[k])
				bg_pool[k] = (k == 0) ? fg_sel : 8'($urandom);
			n_round = $urandom_range(20, 60);
			repeat (n_round) begin
				pick = $urandom_range(99);
				bg = ($urandom_range(9) == 0) ? 8'($urandom) : bg_pool[$urandom_range(5)];
				if (pick < 62) begin
					send_req(CMD_BLEND, 8'($urandom), bg, 8'($urandom),
						8'($urandom), 8'($urandom), 8'($urandom));
					rand_cnt++;
				end else if (pick < 86) begin
					// often repaint a color the round is actually using
					pidx = ($urandom_range(2) == 0) ? bg_pool[$urandom_range(5)]
						: 8'($urandom);
					send_req(CMD_PAL_WR, 8'($urandom), 8'($urandom), pidx,
						8'($urandom), 8'($urandom), 8'($urandom));
					rand_cnt++;
				end else if (pick < 93) begin
					send_req(CMD_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom),
						8'($urandom), 8'($urandom), 8'($urandom));
					rand_cnt++;
				end else begin
					send_req(CMD_NOP, 8'($urandom), 8'($urandom), 8'($urandom),
						8'($urandom), 8'($urandom), 8'($urandom));
					rand_cnt++;
				end
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		// shadow state matches the block after reset
		foreach (pal_shadow[i])
			pal_shadow[i] = '0;
		foreach (cache_ok[i])
			cache_ok[i] = '0;
		foreach (cache_px[i])
			cache_px[i] = '0;
		fg_sel = '0;

		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		in_valid  <= 1'b0;
		cmd       <= CMD_BLEND;
		coverage  <= '0;
		bg_index  <= '0;
		pal_index <= '0;
		red       <= '0;
		green     <= '0;
		blue      <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_palette_ties();
		test_stale_cache();
		test_random_traffic();

		drain_requests();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d requests: %0d palette writes, %0d cache clears, %0d fg_color writes",
			n_sent, n_pal_wr, n_clear, n_cfg);
		$display("blends: %0d cache hits, %0d palette searches, %0d level 0/7; %0d mismatches",
			n_hits, n_scans, n_edge, mism_cnt);
		if (mism_cnt == 0 && pending_px.size() == 0)
			$display("palette_alpha_blend_nearest verification clean");
		else
			$display("palette_alpha_blend_nearest verification failed");
		$finish;
	end

endmodule
